@@ src/kfca_pkg.sv @@
// ----------------------------------------------------------------------------
// kfca_pkg
// Shared types, widths and register indexes of the constant-acceleration
// Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kfca_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CFG_W    = 47;
    localparam int unsigned VAL_W    = 48;
    localparam int unsigned IDX_W    = 3;

    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_Q_POS  = 3'd0,
        REG_Q_VEL  = 3'd1,
        REG_Q_ACC  = 3'd2,
        REG_R_MEAS = 3'd3,
        REG_P0_POS = 3'd4,
        REG_P0_VEL = 3'd5,
        REG_P0_ACC = 3'd6
    } t_reg_idx;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] y;
    } t_alu_rsp;

    function automatic logic [VAL_W-1:0] sat_wide(input logic signed [VAL_W+1:0] v);
        logic [VAL_W-1:0] r;
        if (v > $signed({2'b00, VMAX})) begin
            r = VMAX;
        end else if (v < $signed({2'b11, VMIN})) begin
            r = VMIN;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] signed_mag(input logic [VAL_W+15:0] m,
                                                   input logic neg);
        logic [VAL_W-1:0] r;
        if (neg) begin
            if (m >= {16'd0, VMIN}) begin
                r = VMIN;
            end else begin
                r = VAL_W'(-m[VAL_W-1:0]);
            end
        end else if (m > {16'd0, VMAX}) begin
            r = VMAX;
        end else begin
            r = m[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_out(input logic [VAL_W-1:0] v);
        logic [VAL_W:0] s;
        s = $signed({v[VAL_W-1], v}) + (VAL_W+1)'(32768);
        return s[VAL_W:16] > (VAL_W-15)'(32'h7FFF_FFFF) && !s[VAL_W] ?
               32'h7FFF_FFFF : s[SAMPLE_W+15:16];
    endfunction

endpackage

`default_nettype wire

@@ src/kfca_if.sv @@
// ----------------------------------------------------------------------------
// kfca channel interfaces
// Valid/ready channels for samples, estimates and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface kfca_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        restart;
    modport source (output valid, sample, restart, input ready);
    modport sink   (input valid, sample, restart, output ready);
endinterface

interface kfca_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_est;
    logic [31:0] vel_est;
    logic [31:0] acc_est;
    modport source (output valid, pos_est, vel_est, acc_est, input ready);
    modport sink   (input valid, pos_est, vel_est, acc_est, output ready);
endinterface

interface kfca_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [46:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/kfca_alu.sv @@
// ----------------------------------------------------------------------------
// kfca_alu
// Shared saturating unit: add and subtract, Q16.32 multiply
// from 24-bit partial products, and a bit-serial Q16.32 divide.
// ----------------------------------------------------------------------------
`default_nettype none

module kfca_alu
    import kfca_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_alu_req i_req,
    output t_alu_rsp  o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state            r_state;
    logic [VAL_W-1:0]  r_ma, r_mb;
    logic              r_neg;
    logic [2:0]        r_pp;
    logic [95:0]       r_acc;
    logic [VAL_W-1:0]  r_den;
    logic [VAL_W:0]    r_rem;
    logic [VAL_W+31:0] r_num;
    logic [6:0]        r_cnt;
    logic [VAL_W-1:0]  r_y;

    logic [VAL_W-1:0] w_ma, w_mb;
    logic [VAL_W:0]   w_trial;
    logic [95:0]      w_rnd;
    logic [23:0]      w_pa, w_pb;
    logic [47:0]      w_prod;
    logic [95:0]      w_pp_sh;

    assign w_ma = i_req.a[VAL_W-1] ? VAL_W'(-i_req.a) : i_req.a;
    assign w_mb = i_req.b[VAL_W-1] ? VAL_W'(-i_req.b) : i_req.b;
    assign w_trial = {r_rem[VAL_W-1:0], r_num[VAL_W+31]} - {1'b0, r_den};
    assign w_rnd = r_acc + 96'h8000_0000;

    // One 24x24 partial product per step; bit 0 of the step picks the half
    // of a, bit 1 the half of b.
    assign w_pa = r_pp[0] ? r_ma[47:24] : r_ma[23:0];
    assign w_pb = r_pp[1] ? r_mb[47:24] : r_mb[23:0];
    assign w_prod = 48'(w_pa) * 48'(w_pb);
    assign w_pp_sh = (r_pp[1:0] == 2'd0) ? 96'(w_prod) :
                     (r_pp[1:0] == 2'd3) ? {w_prod, 48'd0} :
                                           {24'd0, w_prod, 24'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op)
                            OP_ADD: begin
                                r_y <= sat_wide($signed({{2{i_req.a[VAL_W-1]}}, i_req.a})
                                              + $signed({{2{i_req.b[VAL_W-1]}}, i_req.b}));
                                r_state <= S_DONE;
                            end
                            OP_SUB: begin
                                r_y <= sat_wide($signed({{2{i_req.a[VAL_W-1]}}, i_req.a})
                                              - $signed({{2{i_req.b[VAL_W-1]}}, i_req.b}));
                                r_state <= S_DONE;
                            end
                            OP_MUL: begin
                                r_ma    <= w_ma;
                                r_mb    <= w_mb;
                                r_neg   <= i_req.a[VAL_W-1] ^ i_req.b[VAL_W-1];
                                r_pp    <= 3'd0;
                                r_acc   <= '0;
                                r_state <= S_MUL;
                            end
                            default: begin
                                // Divisor is positive; only the dividend has a sign.
                                r_neg   <= i_req.a[VAL_W-1];
                                r_num   <= {w_ma, 32'd0};
                                r_den   <= i_req.b;
                                r_rem   <= '0;
                                r_cnt   <= 7'd0;
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_pp == 3'd4) begin
                        r_y <= signed_mag(w_rnd[95:32] > 64'({16'd0, VMIN}) ?
                                          {16'd0, VMIN} + 64'(!r_neg) :
                                          w_rnd[95:32], r_neg);
                        r_state <= S_DONE;
                    end else begin
                        r_acc <= r_acc + w_pp_sh;
                        r_pp  <= r_pp + 3'd1;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[VAL_W+30:0], ~w_trial[VAL_W]};
                    r_rem <= w_trial[VAL_W] ? {r_rem[VAL_W-1:0], r_num[VAL_W+31]}
                                            : w_trial;
                    if (r_cnt == 7'(VAL_W + 31)) begin
                        r_state <= S_DONE;
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_DIV && r_cnt == 7'(VAL_W + 31)) begin
                // Quotient bits above 47 force saturation.
                r_y <= signed_mag({r_num[VAL_W+30:0], ~w_trial[VAL_W]} >
                                  80'({16'd0, VMIN}) ? {16'd0, VMIN} + 64'(!r_neg) :
                                  {r_num[VAL_W+14:0], ~w_trial[VAL_W]}, r_neg);
            end
        end
    end

    assign o_rsp = {(r_state == S_DONE), r_y};

endmodule

`default_nettype wire

@@ src/kalman_filter_const_accel.sv @@
// ----------------------------------------------------------------------------
// kalman_filter_const_accel
// Three-state constant-acceleration Kalman filter for scalar position samples.
// ----------------------------------------------------------------------------
// Each input word is processed by a small sequencer that drives one shared
// saturating unit (add, subtract, multiply, divide). The first three words
// after reset or restart seed the state and give no estimate. Each later
// word runs a predict and a correction and gives one estimate word. An
// update keeps the input not ready until it has finished, so no new word is
// taken while one is in work. It runs 27 adds and subtracts, 9 multiplies
// (four partial products, a rounding step and the hand-off each) and 3
// bit-serial divides, which dominate. The estimate sits in an output
// register, so the input is ready again while it waits; an update that
// finishes before the previous estimate is taken holds until the output
// frees up. Registers are written through the configuration channel while
// no update is running.
`default_nettype none

module kalman_filter_const_accel
    import kfca_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kfca_in_if.sink    i_in,
    kfca_out_if.source o_out,
    kfca_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_cfg [7];
    logic [1:0]       r_warm;
    logic [31:0]      r_s0, r_s1;
    logic [VAL_W-1:0] r_z;
    // Scratch registers: x0..x2, p00 p01 p02 p11 p12 p22, a00.. a22, den, k0..k2, y, xp0 xp1, t
    logic [VAL_W-1:0] r_v [23];
    logic [5:0]       r_step;
    logic             r_ovalid;
    logic [SAMPLE_W-1:0] r_pos, r_vel, r_acc;
    t_alu_req         w_req;
    t_alu_rsp         w_rsp;
    logic [4:0]       w_dst;
    logic             w_last;
    logic             w_load;

    localparam int X0=0, X1=1, X2=2, P00=3, P01=4, P02=5, P11=6, P12=7, P22=8;
    localparam int A00=9, A01=10, A02=11, A11=12, A12=13, A22=14, DEN=15;
    localparam int K0=16, K1=17, K2=18, Y=19, XP0=20, XP1=21, T=22;
    localparam int NSTEP = 39;

    function automatic logic [VAL_W-1:0] cx(input t_reg_idx i);
        return {1'b0, r_cfg[i]};
    endfunction

    // Micro-program: dst <= a op b.
    always_comb begin
        logic [4:0] d;
        t_op o;
        logic [VAL_W-1:0] a, b;
        d = 5'(T); o = OP_ADD; a = '0; b = '0;
        case (r_step)
            6'd0:  begin d=5'(XP0); a=r_v[X0];  b=r_v[X1]; end
            6'd1:  begin d=5'(XP1); a=r_v[X1];  b=r_v[X2]; end
            6'd2:  begin d=5'(A00); a=r_v[P00]; b=r_v[P01]; end
            6'd3:  begin d=5'(A00); a=r_v[A00]; b=r_v[P01]; end
            6'd4:  begin d=5'(A00); a=r_v[A00]; b=r_v[P11]; end
            6'd5:  begin d=5'(A00); a=r_v[A00]; b=cx(REG_Q_POS); end
            6'd6:  begin d=5'(A01); a=r_v[P01]; b=r_v[P11]; end
            6'd7:  begin d=5'(A01); a=r_v[A01]; b=r_v[P02]; end
            6'd8:  begin d=5'(A01); a=r_v[A01]; b=r_v[P12]; end
            6'd9:  begin d=5'(A02); a=r_v[P02]; b=r_v[P12]; end
            6'd10: begin d=5'(A11); a=r_v[P11]; b=r_v[P12]; end
            6'd11: begin d=5'(A11); a=r_v[A11]; b=r_v[P12]; end
            6'd12: begin d=5'(A11); a=r_v[A11]; b=r_v[P22]; end
            6'd13: begin d=5'(A11); a=r_v[A11]; b=cx(REG_Q_VEL); end
            6'd14: begin d=5'(A12); a=r_v[P12]; b=r_v[P22]; end
            6'd15: begin d=5'(A22); a=r_v[P22]; b=cx(REG_Q_ACC); end
            6'd16: begin d=5'(DEN); a=r_v[A00]; b=cx(REG_R_MEAS); end
            6'd17: begin d=5'(K0); o=OP_DIV; a=r_v[A00]; b=r_v[DEN]; end
            6'd18: begin d=5'(K1); o=OP_DIV; a=r_v[A01]; b=r_v[DEN]; end
            6'd19: begin d=5'(K2); o=OP_DIV; a=r_v[A02]; b=r_v[DEN]; end
            6'd20: begin d=5'(Y);  o=OP_SUB; a=r_z; b=r_v[XP0]; end
            6'd21: begin d=5'(T);  o=OP_MUL; a=r_v[K0]; b=r_v[Y]; end
            6'd22: begin d=5'(X0); a=r_v[XP0]; b=r_v[T]; end
            6'd23: begin d=5'(T);  o=OP_MUL; a=r_v[K1]; b=r_v[Y]; end
            6'd24: begin d=5'(X1); a=r_v[XP1]; b=r_v[T]; end
            6'd25: begin d=5'(T);  o=OP_MUL; a=r_v[K2]; b=r_v[Y]; end
            6'd26: begin d=5'(X2); a=r_v[X2]; b=r_v[T]; end
            6'd27: begin d=5'(T);  o=OP_MUL; a=r_v[K0]; b=r_v[A00]; end
            6'd28: begin d=5'(P00); o=OP_SUB; a=r_v[A00]; b=r_v[T]; end
            6'd29: begin d=5'(T);  o=OP_MUL; a=r_v[K0]; b=r_v[A01]; end
            6'd30: begin d=5'(P01); o=OP_SUB; a=r_v[A01]; b=r_v[T]; end
            6'd31: begin d=5'(T);  o=OP_MUL; a=r_v[K0]; b=r_v[A02]; end
            6'd32: begin d=5'(P02); o=OP_SUB; a=r_v[A02]; b=r_v[T]; end
            6'd33: begin d=5'(T);  o=OP_MUL; a=r_v[K1]; b=r_v[A01]; end
            6'd34: begin d=5'(P11); o=OP_SUB; a=r_v[A11]; b=r_v[T]; end
            6'd35: begin d=5'(T);  o=OP_MUL; a=r_v[K1]; b=r_v[A02]; end
            6'd36: begin d=5'(P12); o=OP_SUB; a=r_v[A12]; b=r_v[T]; end
            6'd37: begin d=5'(T);  o=OP_MUL; a=r_v[K2]; b=r_v[A02]; end
            default: begin d=5'(P22); o=OP_SUB; a=r_v[A22]; b=r_v[T]; end
        endcase
        // A non-positive innovation variance divides by one LSB instead.
        if (o == OP_DIV && (b[VAL_W-1] || b == '0)) begin
            b = VAL_W'(1);
        end
        w_req.start = (r_state == S_RUN);
        w_req.op    = o;
        w_req.a     = a;
        w_req.b     = b;
        w_dst       = d;
    end

    kfca_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    logic signed [33:0] w_dv, w_da;
    assign w_dv = $signed({{2{i_in.sample[31]}}, i_in.sample})
                - $signed({{2{r_s0[31]}}, r_s0});
    assign w_da = $signed({{2{i_in.sample[31]}}, i_in.sample})
                - $signed({r_s1[31], r_s1, 1'b0})
                + $signed({{2{r_s0[31]}}, r_s0});

    // The estimate register takes a finished update when it is empty or
    // its word leaves in the same cycle.
    assign w_last = (r_state == S_WAIT) && w_rsp.done && (r_step == 6'(NSTEP - 1));
    assign w_load = (w_last || r_state == S_OUT) && (!r_ovalid || o_out.ready);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.pos_est = r_pos;
    assign o_out.vel_est = r_vel;
    assign o_out.acc_est = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_warm   <= 2'd0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_cfg[0] <= CFG_W'(429497);
            r_cfg[1] <= CFG_W'(214748);
            r_cfg[2] <= CFG_W'(4295);
            r_cfg[3] <= CFG_W'(42949673);
            r_cfg[4] <= CFG_W'(64'd8589934592);
            r_cfg[5] <= CFG_W'(64'd25769803776);
            r_cfg[6] <= CFG_W'(64'd34359738368);
        end else begin
            if (i_cfg.valid && i_cfg.ready && i_cfg.index <= REG_P0_ACC) begin
                r_cfg[i_cfg.index] <= i_cfg.data;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_pos    <= to_out(r_v[X0]);
                r_vel    <= to_out(r_v[X1]);
                r_acc    <= to_out(r_v[X2]);
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_z <= {i_in.sample, 16'd0};
                        if (i_in.restart || r_warm == 2'd0) begin
                            r_s0 <= i_in.sample; r_warm <= 2'd1;
                        end else if (r_warm == 2'd1) begin
                            r_s1 <= i_in.sample; r_warm <= 2'd2;
                        end else if (r_warm == 2'd2) begin
                            r_v[X0]  <= {i_in.sample, 16'd0};
                            r_v[X1]  <= {w_dv[32:0], 15'd0};
                            r_v[X2]  <= sat_wide(50'($signed(w_da) * 50'sd65536));
                            r_v[P00] <= cx(REG_P0_POS); r_v[P01] <= '0; r_v[P02] <= '0;
                            r_v[P11] <= cx(REG_P0_VEL); r_v[P12] <= '0;
                            r_v[P22] <= cx(REG_P0_ACC);
                            r_warm <= 2'd3;
                        end else begin
                            r_step  <= '0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_v[w_dst] <= w_rsp.y;
                        if (r_step == 6'(NSTEP - 1)) begin
                            r_state <= w_load ? S_IDLE : S_OUT;
                        end else begin
                            r_step  <= r_step + 6'd1;
                            r_state <= S_RUN;
                        end
                    end
                end
                default: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire
